### rtl/internet_checksum_pseudo_header_unit_defines.svh
// ----------------------------------------------------------------------------
// Internet checksum unit assertion macros
// Shared assertion macros. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef INTERNET_CHECKSUM_PSEUDO_HEADER_UNIT_DEFINES_SVH
`define INTERNET_CHECKSUM_PSEUDO_HEADER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Implication checked on every rising edge outside reset.
`define ICPH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define ICPH_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ICPH_ASSERT(lbl, prop, msg)
`define ICPH_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

### rtl/icph_pkg.sv
// ----------------------------------------------------------------------------
// Internet checksum package
// Shared types, constants and the ones'-complement adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package icph_pkg;

    // Byte count codes of one input word.
    localparam logic [1:0] BCNT_NONE  = 2'd0;
    localparam logic [1:0] BCNT_ONE   = 2'd1;
    localparam logic [1:0] BCNT_TWO   = 2'd2;
    localparam logic [1:0] BCNT_THREE = 2'd3;

    // Masks for 16-bit words.
    localparam logic [15:0] WORD_MASK      = 16'hFFFF;
    localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;

    // Queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified request as it travels through the queue.
    typedef struct packed {
        logic        first;
        logic        last;
        logic        pseudo;
        logic [15:0] word_term;
        logic [1:0]  inc;
        logic [15:0] pseudo_sum;
    } icph_entry_t;

    // Ones'-complement add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'b0, s[16]};
        return f[15:0];
    endfunction

endpackage

### rtl/internet_checksum_pseudo_header_unit.sv
// A final word passes through the queue and then the output register before its
// result is valid. Throughput: one word per cycle, sustained, while results
// are taken; the two-entry queue and the output register set that figure.
// Reset (rst_n low, asynchronous) clears the running sum, byte total, mode,
// queue and result valid.
// ----------------------------------------------------------------------------
// Internet checksum unit with pseudo-header
// Ones'-complement checksum over 16-bit packet words, with optional
// TCP/UDP pseudo-header and self-counted length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module internet_checksum_pseudo_header_unit
    import icph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        first_item,
    input  logic        last_item,
    input  logic [15:0] data_word,
    input  logic [1:0]  byte_count,
    input  logic        with_pseudo,
    input  logic [31:0] src_address,
    input  logic [31:0] dst_address,
    input  logic [7:0]  protocol,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [15:0] checksum,
    output logic [15:0] packet_bytes
);

    icph_entry_t front_entry;
    icph_entry_t q_head;
    logic        q_not_full;
    logic        q_not_empty;
    logic        q_push;
    logic        q_pop;

    // Accept a request whenever the queue has room.
    assign item_ready = q_not_full;
    assign q_push     = item_valid && q_not_full;

    icph_front u_front (
        .first_item  (first_item),
        .last_item   (last_item),
        .data_word   (data_word),
        .byte_count  (byte_count),
        .with_pseudo (with_pseudo),
        .src_address (src_address),
        .dst_address (dst_address),
        .protocol    (protocol),
        .entry       (front_entry)
    );

    icph_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (front_entry),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    icph_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .checksum     (checksum),
        .packet_bytes (packet_bytes)
    );

endmodule

### rtl/icph_front.sv
// ----------------------------------------------------------------------------
// Internet checksum front end
// Classifies each request: pads the word, decodes the byte increment and
// folds the pseudo-header fields into one 16-bit term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icph_front
    import icph_pkg::*;
(
    input  logic              first_item,
    input  logic              last_item,
    input  logic [15:0]       data_word,
    input  logic [1:0]        byte_count,
    input  logic              with_pseudo,
    input  logic [31:0]       src_address,
    input  logic [31:0]       dst_address,
    input  logic [7:0]        protocol,
    output icph_entry_t       entry
);

    logic [15:0] word_term;
    logic [1:0]  inc;
    logic [18:0] raw_sum;
    logic [16:0] fold1;
    logic [16:0] fold2;

    // Pad an odd byte with zero and decode the byte increment.
    always_comb
    begin
        unique case (byte_count) inside
            BCNT_NONE:
            begin
                word_term = '0;
                inc       = 2'd0;
            end
            BCNT_ONE:
            begin
                word_term = data_word & HIGH_BYTE_MASK;
                inc       = 2'd1;
            end
            BCNT_TWO, BCNT_THREE:
            begin
                word_term = data_word & WORD_MASK;
                inc       = 2'd2;
            end
            default:
            begin
                word_term = '0;
                inc       = 2'd0;
            end
        endcase
    end

    // Sum the address halves and the protocol, and fold twice back into 16 bits.
    always_comb
    begin
        raw_sum = {3'b0, src_address[15:0]} + {3'b0, src_address[31:16]}
                + {3'b0, dst_address[15:0]} + {3'b0, dst_address[31:16]}
                + {11'b0, protocol};
        fold1   = {1'b0, raw_sum[15:0]} + {14'b0, raw_sum[18:16]};
        fold2   = {1'b0, fold1[15:0]} + {16'b0, fold1[16]};
    end

    // Assemble the queue entry.
    always_comb
    begin
        entry.first      = first_item;
        entry.last       = last_item;
        entry.pseudo     = with_pseudo;
        entry.word_term  = word_term;
        entry.inc        = inc;
        entry.pseudo_sum = with_pseudo ? fold2[15:0] : 16'h0000;
    end

endmodule

### rtl/icph_queue.sv
// ----------------------------------------------------------------------------
// Internet checksum request queue
// Short FIFO that decouples the front end from the accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "internet_checksum_pseudo_header_unit_defines.svh"

module icph_queue
    import icph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  icph_entry_t push_entry,
    output logic        not_full,
    input  logic        pop,
    output logic        not_empty,
    output icph_entry_t head
);

    icph_entry_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg;
    logic [QCNT_W-1:0]       count_next;

    localparam logic [QCNT_W-1:0] FULL_COUNT = QCNT_W'(QDEPTH);
    localparam logic [QPTR_W-1:0] LAST_PTR   = QPTR_W'(QDEPTH - 1);

    assign not_full  = (count_reg != FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `ICPH_ASSERT_NEVER(a_no_overflow, push && !not_full, "queue push while full")
    `ICPH_ASSERT_NEVER(a_no_underflow, pop && !not_empty, "queue pop while empty")
    `ICPH_ASSERT(a_count_bound, (count_reg <= FULL_COUNT), "queue count out of range")

endmodule

### rtl/icph_back.sv
// ----------------------------------------------------------------------------
// Internet checksum accumulator
// Adds each queued request into the running sum and byte total and
// registers the checksum result of the final word of a packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "internet_checksum_pseudo_header_unit_defines.svh"

module icph_back
    import icph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  icph_entry_t q_head,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [15:0] checksum,
    output logic [15:0] packet_bytes
);

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [15:0] total_reg;
    logic [15:0] total_next;
    logic        mode_reg;
    logic        mode_next;
    logic        valid_reg;
    logic        valid_next;
    logic [15:0] checksum_reg;
    logic [15:0] bytes_reg;
    logic [15:0] base_sum;
    logic [15:0] base_total;
    logic [15:0] final_sum;
    logic        load_result;

    // A non-final request never waits; a final one needs a free output slot.
    assign pop = q_not_empty && (!q_head.last || !valid_reg || result_ready);
    assign load_result = pop && q_head.last;

    // Accumulate the word, restarting from the pseudo-header term on a first word.
    always_comb
    begin
        base_sum   = q_head.first ? q_head.pseudo_sum : sum_reg;
        base_total = q_head.first ? 16'h0000 : total_reg;
        sum_next   = oc_add(base_sum, q_head.word_term);
        total_next = base_total + {14'b0, q_head.inc};
        mode_next  = q_head.first ? q_head.pseudo : mode_reg;
        final_sum  = mode_next ? oc_add(sum_next, total_next) : sum_next;
    end

    // Output valid tracking.
    always_comb
    begin
        valid_next = valid_reg;
        if (valid_reg && result_ready)
        begin
            valid_next = 1'b0;
        end
        if (load_result)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            total_reg <= '0;
            mode_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                sum_reg   <= sum_next;
                total_reg <= total_next;
                mode_reg  <= mode_next;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            checksum_reg <= ~final_sum;
            bytes_reg    <= total_next;
        end
    end

    assign result_valid = valid_reg;
    assign checksum     = checksum_reg;
    assign packet_bytes = bytes_reg;

    `ICPH_ASSERT(a_last_gives_result, load_result |=> valid_reg, "final word lost its result")
    `ICPH_ASSERT(a_no_spurious_result, (pop && !q_head.last && !valid_reg) |=> !valid_reg, "result without final word")
    `ICPH_ASSERT(a_first_restarts_count, (pop && q_head.first) |=> (total_reg == {14'b0, $past(q_head.inc)}), "byte total not restarted")

endmodule
